// ===== hdl/bvpid_pkg.sv =====
// Shared types and constants for the boost voltage PID loop.
`default_nettype none
package bvpid_pkg;

    // Compensator coefficients, Q8
    localparam logic signed [17:0] COEF_B0 = 18'sd8860;
    localparam logic signed [17:0] COEF_B1 = -18'sd17445;
    localparam logic signed [17:0] COEF_B2 = 18'sd8588;

    localparam int CAL_SHIFT = 12;
    localparam int ACC_SHIFT = 8;

    // Saturation limits of the error, 17-bit signed range
    localparam logic signed [18:0] ERR_HI = 19'sd65535;
    localparam logic signed [18:0] ERR_LO = -19'sd65536;

    // Configuration register indexes
    localparam logic [2:0] CFG_CAL_GAIN   = 3'd0;
    localparam logic [2:0] CFG_CAL_OFFSET = 3'd1;
    localparam logic [2:0] CFG_BOOST_MAX  = 3'd2;
    localparam logic [2:0] CFG_BOOST_MIN  = 3'd3;
    localparam logic [2:0] CFG_BUCK_MAX   = 3'd4;
    localparam logic [2:0] CFG_BUCK_MIN   = 3'd5;
    localparam logic [2:0] CFG_PWM_PERIOD = 3'd6;

    // Configuration reset values
    localparam logic [15:0] RST_CAL_GAIN   = 16'd4096;
    localparam logic [12:0] RST_CAL_OFFSET = 13'd0;
    localparam logic [11:0] RST_BOOST_MAX  = 12'd4095;
    localparam logic [11:0] RST_BOOST_MIN  = 12'd0;
    localparam logic [11:0] RST_BUCK_MAX   = 12'd3809;
    localparam logic [11:0] RST_BUCK_MIN   = 12'd0;
    localparam logic [15:0] RST_PWM_PERIOD = 16'd65535;

    // Operand selection of the shared multiplier
    localparam logic [2:0] MUL_NONE  = 3'd0;
    localparam logic [2:0] MUL_CAL   = 3'd1;
    localparam logic [2:0] MUL_BUCK  = 3'd2;
    localparam logic [2:0] MUL_E0    = 3'd3;
    localparam logic [2:0] MUL_E1    = 3'd4;
    localparam logic [2:0] MUL_E2    = 3'd5;
    localparam logic [2:0] MUL_BOOST = 3'd6;

    typedef struct packed {
        logic       ld_in;
        logic [2:0] mul_sel;
        logic       ld_err;
        logic       ld_buck;
        logic       sum_init;
        logic       sum_add;
        logic       ld_duty;
        logic       ld_out;
    } t_cmd;

endpackage
`default_nettype wire

// ===== hdl/bvpid_dp.sv =====
// Datapath: configuration registers, shared multiplier, loop state and result registers.
`default_nettype none
module bvpid_dp
    import bvpid_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [11:0] i_adc_sample,
    input  wire logic [11:0] i_target,
    input  wire logic        i_pwm_enable,
    output logic [11:0]      o_boost_duty,
    output logic [15:0]      o_buck_compare,
    output logic [14:0]      o_adc_trigger_compare,
    output logic [15:0]      o_boost_compare
);

    logic [15:0] r_cal_gain;
    logic [12:0] r_cal_offset;
    logic [11:0] r_boost_max;
    logic [11:0] r_boost_min;
    logic [11:0] r_buck_max;
    logic [11:0] r_buck_min;
    logic [15:0] r_period;

    logic [11:0] r_adc;
    logic [11:0] r_tgt;
    logic        r_en;

    logic [31:0] r_prod;
    logic [16:0] r_err;
    logic [16:0] r_e1;
    logic [16:0] r_e2;
    logic [31:0] r_acc;
    logic [31:0] r_sum;
    logic [11:0] r_duty;
    logic [15:0] r_buck_cmp;

    logic [11:0]        r_out_duty;
    logic [15:0]        r_out_buck;
    logic [15:0]        r_out_boost;

    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] mul_p;
    logic [11:0]        buck_duty;
    logic signed [18:0] vcal;
    logic signed [18:0] err_full;
    logic [16:0]        n_err;
    logic [31:0]        final_sum;
    logic signed [23:0] duty_raw;
    logic signed [23:0] duty_max;
    logic signed [23:0] duty_min;
    logic signed [23:0] duty_hi;
    logic signed [23:0] duty_lo;

    assign buck_duty = r_en ? r_buck_max : r_buck_min;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_CAL: begin
                mul_a = $signed({6'd0, r_adc});
                mul_b = $signed({2'd0, r_cal_gain});
            end
            MUL_BUCK: begin
                mul_a = $signed({6'd0, buck_duty});
                mul_b = $signed({2'd0, r_period});
            end
            MUL_E0: begin
                mul_a = $signed({r_err[16], r_err});
                mul_b = COEF_B0;
            end
            MUL_E1: begin
                mul_a = $signed({r_e1[16], r_e1});
                mul_b = COEF_B1;
            end
            MUL_E2: begin
                mul_a = $signed({r_e2[16], r_e2});
                mul_b = COEF_B2;
            end
            MUL_BOOST: begin
                mul_a = $signed({6'd0, r_duty});
                mul_b = $signed({2'd0, r_period});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Calibrate the sample and saturate the error to 17 bits
    always_comb begin
        vcal     = $signed({3'd0, r_prod[CAL_SHIFT +: 16]})
                 + $signed({{6{r_cal_offset[12]}}, r_cal_offset});
        err_full = $signed({7'd0, r_tgt}) - vcal;
        if (err_full > ERR_HI) begin
            n_err = ERR_HI[16:0];
        end else if (err_full < ERR_LO) begin
            n_err = ERR_LO[16:0];
        end else begin
            n_err = err_full[16:0];
        end
    end

    // Close the accumulation and clamp the duty, maximum first
    always_comb begin
        final_sum = r_sum + r_prod;
        duty_raw  = $signed(final_sum[31:ACC_SHIFT]);
        duty_max  = $signed({12'd0, r_boost_max});
        duty_min  = $signed({12'd0, r_boost_min});
        duty_hi   = (duty_raw > duty_max) ? duty_max : duty_raw;
        duty_lo   = (duty_hi < duty_min) ? duty_min : duty_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_gain   <= RST_CAL_GAIN;
            r_cal_offset <= RST_CAL_OFFSET;
            r_boost_max  <= RST_BOOST_MAX;
            r_boost_min  <= RST_BOOST_MIN;
            r_buck_max   <= RST_BUCK_MAX;
            r_buck_min   <= RST_BUCK_MIN;
            r_period     <= RST_PWM_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAL_GAIN:   r_cal_gain   <= i_cfg_data;
                CFG_CAL_OFFSET: r_cal_offset <= i_cfg_data[12:0];
                CFG_BOOST_MAX:  r_boost_max  <= i_cfg_data[11:0];
                CFG_BOOST_MIN:  r_boost_min  <= i_cfg_data[11:0];
                CFG_BUCK_MAX:   r_buck_max   <= i_cfg_data[11:0];
                CFG_BUCK_MIN:   r_buck_min   <= i_cfg_data[11:0];
                CFG_PWM_PERIOD: r_period     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_e1  <= '0;
            r_e2  <= '0;
        end else if (i_cmd.ld_duty) begin
            r_acc <= final_sum;
            r_e2  <= r_e1;
            r_e1  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[31:0];
        if (i_cmd.ld_in) begin
            r_adc <= i_adc_sample;
            r_tgt <= i_target;
            r_en  <= i_pwm_enable;
        end
        if (i_cmd.ld_err) begin
            r_err <= n_err;
        end
        if (i_cmd.ld_buck) begin
            r_buck_cmp <= r_prod[CAL_SHIFT +: 16];
        end
        if (i_cmd.sum_init) begin
            r_sum <= r_acc + r_prod;
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + r_prod;
        end
        if (i_cmd.ld_duty) begin
            r_duty <= duty_lo[11:0];
        end
        if (i_cmd.ld_out) begin
            r_out_duty  <= r_duty;
            r_out_buck  <= r_buck_cmp;
            r_out_boost <= r_period - r_prod[CAL_SHIFT +: 16];
        end
    end

    assign o_boost_duty          = r_out_duty;
    assign o_buck_compare        = r_out_buck;
    assign o_adc_trigger_compare = r_out_buck[15:1];
    assign o_boost_compare       = r_out_boost;

endmodule
`default_nettype wire

// ===== hdl/bvpid_ctrl.sv =====
// Controller: sequences one loop update over the shared multiplier and owns the handshakes.
`default_nettype none
module bvpid_ctrl
    import bvpid_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CAL   = 4'd1;
    localparam logic [3:0] ST_ERR   = 4'd2;
    localparam logic [3:0] ST_E0    = 4'd3;
    localparam logic [3:0] ST_E1    = 4'd4;
    localparam logic [3:0] ST_E2    = 4'd5;
    localparam logic [3:0] ST_DUTY  = 4'd6;
    localparam logic [3:0] ST_BOOST = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       accept;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE) || ((r_state == ST_FIN) && out_free);
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_ready;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_cmd.ld_in   = accept;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CAL;
                end
            end
            ST_CAL: begin
                o_cmd.mul_sel = MUL_CAL;
                n_state       = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.ld_err  = 1'b1;
                o_cmd.mul_sel = MUL_BUCK;
                n_state       = ST_E0;
            end
            ST_E0: begin
                o_cmd.ld_buck = 1'b1;
                o_cmd.mul_sel = MUL_E0;
                n_state       = ST_E1;
            end
            ST_E1: begin
                o_cmd.sum_init = 1'b1;
                o_cmd.mul_sel  = MUL_E1;
                n_state        = ST_E2;
            end
            ST_E2: begin
                o_cmd.sum_add = 1'b1;
                o_cmd.mul_sel = MUL_E2;
                n_state       = ST_DUTY;
            end
            ST_DUTY: begin
                o_cmd.ld_duty = 1'b1;
                n_state       = ST_BOOST;
            end
            ST_BOOST: begin
                o_cmd.mul_sel = MUL_BOOST;
                n_state       = ST_FIN;
            end
            ST_FIN: begin
                // keep the boost product in place while the result slot is busy
                o_cmd.mul_sel = MUL_BOOST;
                // hold until the result slot frees, take the next request at once
                if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = accept ? ST_CAL : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/boost_voltage_pid_loop.sv =====
// A result is valid once the controller has stepped from CAL through FIN,
// waiting in FIN while the result slot is busy. A request is taken only
// after the last has run its six products on the shared 18x18 multiplier.
// A new request is taken while the previous result still waits at the output.
// Reset (synchronous, active low) clears the accumulator and error history
// and loads the configuration registers with their defaults.
`default_nettype none
module boost_voltage_pid_loop
    import bvpid_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [11:0] i_adc_sample,
    input  wire logic [11:0] i_target,
    input  wire logic        i_pwm_enable,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_boost_duty,
    output logic [15:0]      o_buck_compare,
    output logic [14:0]      o_adc_trigger_compare,
    output logic [15:0]      o_boost_compare
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    bvpid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    bvpid_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_cfg_we              (i_cfg_valid),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_adc_sample          (i_adc_sample),
        .i_target              (i_target),
        .i_pwm_enable          (i_pwm_enable),
        .o_boost_duty          (o_boost_duty),
        .o_buck_compare        (o_buck_compare),
        .o_adc_trigger_compare (o_adc_trigger_compare),
        .o_boost_compare       (o_boost_compare)
    );

endmodule
`default_nettype wire
